### rtl/core/commit_log_scan_verifier_core_defines.svh
// ----------------------------------------------------------------------------
// Commit log scan verifier assertion macros
// Shared assertion shorthands for the commit log scan verifier modules.
// ----------------------------------------------------------------------------
`ifndef COMMIT_LOG_SCAN_VERIFIER_CORE_DEFINES_SVH
`define COMMIT_LOG_SCAN_VERIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/clsv_pkg.sv
// ----------------------------------------------------------------------------
// Commit log scan verifier package
// Types, constants and the CRC step shared by the verifier modules.
// ----------------------------------------------------------------------------
package clsv_pkg;

  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_TRAILER  = 2'd1,
    EV_COMMIT   = 2'd2,
    EV_DAMAGED  = 2'd3
  } event_t;

  localparam int IDX_W = 5;

  localparam logic [IDX_W-1:0] IDX_TYPE      = 5'd0;
  localparam logic [IDX_W-1:0] IDX_LEN       = 5'd1;
  localparam logic [IDX_W-1:0] IDX_LEN_PAD0  = 5'd2;
  localparam logic [IDX_W-1:0] IDX_LEN_PAD1  = 5'd3;
  localparam logic [IDX_W-1:0] IDX_LEN_PAD2  = 5'd4;
  localparam logic [IDX_W-1:0] IDX_MAGIC0    = 5'd5;
  localparam logic [IDX_W-1:0] IDX_MAGIC1    = 5'd6;
  localparam logic [IDX_W-1:0] IDX_MAGIC2    = 5'd7;
  localparam logic [IDX_W-1:0] IDX_MAGIC3    = 5'd8;
  localparam logic [IDX_W-1:0] IDX_CRC_FIRST = 5'd9;
  localparam logic [IDX_W-1:0] IDX_CRC_LAST  = 5'd12;
  localparam logic [IDX_W-1:0] IDX_LEN_FIRST = 5'd13;
  localparam logic [IDX_W-1:0] IDX_LEN_LAST  = 5'd16;
  localparam logic [IDX_W-1:0] TRAILER_BYTES = 5'd17;
  localparam logic [IDX_W-1:0] IDX_MAX       = 5'd31;

  localparam logic [7:0]  TRAILER_PAYLOAD = 8'd12;
  localparam logic [7:0]  MAGIC_0         = 8'h42;
  localparam logic [7:0]  MAGIC_1         = 8'h4A;
  localparam logic [7:0]  MAGIC_2         = 8'h43;
  localparam logic [7:0]  MAGIC_3         = 8'h31;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic type_ok;
    logic len_ok;
    logic zero_ok;
    logic magic0_ok;
    logic magic1_ok;
    logic magic2_ok;
    logic magic3_ok;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        record_last;
    logic        record_is_end;
    logic        record_bad;
    logic        stream_last;
    byte_class_t cls;
  } front_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

### rtl/core/clsv_fifo.sv
// ----------------------------------------------------------------------------
// Commit log scan verifier queue
// Small first-in first-out queue in flip-flops with push/full and pop/empty.
// ----------------------------------------------------------------------------
`include "commit_log_scan_verifier_core_defines.svh"

module clsv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `CLSV_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_FULL, "queue count exceeds depth")
  `CLSV_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_r == $past(count_r) + CNT_W'(1), "push did not grow the queue")
  `CLSV_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_r == $past(count_r) - CNT_W'(1), "pop did not shrink the queue")

endmodule

### rtl/core/clsv_front.sv
// ----------------------------------------------------------------------------
// Commit log scan verifier front end
// Holds the type code register and classifies each incoming byte against the
// trailer pattern before it enters the middle queue.
// ----------------------------------------------------------------------------
module clsv_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_record_last,
  input  logic                 in_record_is_end,
  input  logic                 in_record_bad,
  input  logic                 in_stream_last,
  output logic                 q_push,
  output clsv_pkg::front_item_t q_item,
  input  logic                 q_full
);

  import clsv_pkg::*;

  logic [7:0] type_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_code_r <= 8'd0;
    end else if (cfg_we) begin
      type_code_r <= cfg_wdata;
    end
  end

  assign full   = q_full;
  assign q_push = push;

  always_comb begin
    q_item.data_byte     = in_data_byte;
    q_item.record_last   = in_record_last;
    q_item.record_is_end = in_record_is_end;
    q_item.record_bad    = in_record_bad;
    q_item.stream_last   = in_stream_last;
    q_item.cls.type_ok   = (in_data_byte == type_code_r);
    q_item.cls.len_ok    = (in_data_byte == TRAILER_PAYLOAD);
    q_item.cls.zero_ok   = (in_data_byte == 8'd0);
    q_item.cls.magic0_ok = (in_data_byte == MAGIC_0);
    q_item.cls.magic1_ok = (in_data_byte == MAGIC_1);
    q_item.cls.magic2_ok = (in_data_byte == MAGIC_2);
    q_item.cls.magic3_ok = (in_data_byte == MAGIC_3);
  end

endmodule

### rtl/core/clsv_back.sv
// ----------------------------------------------------------------------------
// Commit log scan verifier back end
// Runs the commit CRC, trailer capture and commit checks, one byte a cycle
// when the output queue has room, and pushes each result into that queue.
// ----------------------------------------------------------------------------
`include "commit_log_scan_verifier_core_defines.svh"

module clsv_back #(
  parameter int OFFSET_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  clsv_pkg::front_item_t       q_item,
  output logic                        q_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output logic [OFFSET_WIDTH+3:0]     res_data
);

  import clsv_pkg::*;

  localparam int OW = OFFSET_WIDTH;

  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      crc_start_r, crc_start_nxt;
  logic [OW-1:0]    pos_r, pos_nxt;
  logic [OW-1:0]    commit_start_r, commit_start_nxt;
  logic [OW-1:0]    good_end_r, good_end_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             shape_ok_r, shape_ok_nxt;
  logic             pending_r, pending_nxt;
  logic [31:0]      tr_crc_r, tr_crc_nxt;
  logic [31:0]      tr_len_r, tr_len_nxt;
  logic             damaged_r, damaged_nxt;

  logic             fire;
  logic             emit;
  event_t           ev;
  logic             shape_byte;
  logic [31:0]      crc_step;
  logic [OW-1:0]    pos_step;
  logic             is_tr;
  logic             mismatch;
  logic             clean;

  assign fire  = q_valid && !res_full;
  assign q_pop = fire;

  always_comb begin
    unique case (idx_r)
      IDX_TYPE:     shape_byte = q_item.cls.type_ok;
      IDX_LEN:      shape_byte = q_item.cls.len_ok;
      IDX_LEN_PAD0,
      IDX_LEN_PAD1,
      IDX_LEN_PAD2: shape_byte = q_item.cls.zero_ok;
      IDX_MAGIC0:   shape_byte = q_item.cls.magic0_ok;
      IDX_MAGIC1:   shape_byte = q_item.cls.magic1_ok;
      IDX_MAGIC2:   shape_byte = q_item.cls.magic2_ok;
      IDX_MAGIC3:   shape_byte = q_item.cls.magic3_ok;
      default:      shape_byte = (idx_r < TRAILER_BYTES);
    endcase
  end

  assign crc_step = crc_byte(crc_r, q_item.data_byte);
  assign pos_step = pos_r + OW'(1);

  always_comb begin
    crc_nxt          = crc_r;
    crc_start_nxt    = crc_start_r;
    pos_nxt          = pos_r;
    commit_start_nxt = commit_start_r;
    good_end_nxt     = good_end_r;
    idx_nxt          = idx_r;
    shape_ok_nxt     = shape_ok_r;
    pending_nxt      = pending_r;
    tr_crc_nxt       = tr_crc_r;
    tr_len_nxt       = tr_len_r;
    damaged_nxt      = damaged_r;
    emit             = 1'b0;
    ev               = EV_DATA;
    is_tr            = 1'b0;
    mismatch         = 1'b0;
    clean            = 1'b0;

    if (fire) begin
      if (damaged_r) begin
        emit = q_item.stream_last;
        ev   = EV_DAMAGED;
      end else if (q_item.record_bad) begin
        damaged_nxt = 1'b1;
        emit        = 1'b1;
        ev          = EV_DAMAGED;
      end else begin
        if (idx_r == IDX_TYPE) begin
          crc_start_nxt = crc_r;
          shape_ok_nxt  = shape_byte;
        end else begin
          shape_ok_nxt  = shape_ok_r && shape_byte;
        end
        if (!pending_r) begin
          if (idx_r >= IDX_CRC_FIRST && idx_r <= IDX_CRC_LAST) begin
            tr_crc_nxt = {q_item.data_byte, tr_crc_r[31:8]};
          end else if (idx_r >= IDX_LEN_FIRST && idx_r <= IDX_LEN_LAST) begin
            tr_len_nxt = {q_item.data_byte, tr_len_r[31:8]};
          end
        end
        crc_nxt = crc_step;
        pos_nxt = pos_step;

        if (q_item.record_last) begin
          emit    = 1'b1;
          idx_nxt = '0;
          is_tr   = shape_ok_nxt && (idx_r == IDX_LEN_LAST);
          if (is_tr) begin
            if (pending_r) begin
              damaged_nxt = 1'b1;
              ev          = EV_DAMAGED;
            end else begin
              pending_nxt = 1'b1;
              crc_nxt     = crc_start_nxt;
              ev          = EV_TRAILER;
            end
          end else begin
            mismatch = !q_item.record_is_end ||
                       (OW'(tr_len_r) != (pos_step - commit_start_r)) ||
                       (crc_step != tr_crc_r);
            if (pending_r && mismatch) begin
              damaged_nxt = 1'b1;
              ev          = EV_DAMAGED;
            end else if (q_item.record_is_end) begin
              good_end_nxt     = pos_step;
              commit_start_nxt = pos_step;
              crc_nxt          = '0;
              pending_nxt      = 1'b0;
              ev               = EV_COMMIT;
            end else begin
              ev = EV_DATA;
            end
          end
        end else begin
          idx_nxt = (idx_r < IDX_MAX) ? idx_r + IDX_W'(1) : IDX_MAX;
          if (q_item.stream_last) begin
            damaged_nxt = 1'b1;
            emit        = 1'b1;
            ev          = EV_DAMAGED;
          end
        end
      end

      clean = q_item.stream_last && !damaged_nxt && (good_end_nxt == pos_nxt);
    end

    res_push = fire && emit;
    res_data = {ev, good_end_nxt, q_item.stream_last, clean};

    if (fire && q_item.stream_last) begin
      crc_nxt          = '0;
      crc_start_nxt    = '0;
      pos_nxt          = '0;
      commit_start_nxt = '0;
      good_end_nxt     = '0;
      idx_nxt          = '0;
      shape_ok_nxt     = 1'b1;
      pending_nxt      = 1'b0;
      tr_crc_nxt       = '0;
      tr_len_nxt       = '0;
      damaged_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r          <= '0;
      crc_start_r    <= '0;
      pos_r          <= '0;
      commit_start_r <= '0;
      good_end_r     <= '0;
      idx_r          <= '0;
      shape_ok_r     <= 1'b1;
      pending_r      <= 1'b0;
      tr_crc_r       <= '0;
      tr_len_r       <= '0;
      damaged_r      <= 1'b0;
    end else begin
      crc_r          <= crc_nxt;
      crc_start_r    <= crc_start_nxt;
      pos_r          <= pos_nxt;
      commit_start_r <= commit_start_nxt;
      good_end_r     <= good_end_nxt;
      idx_r          <= idx_nxt;
      shape_ok_r     <= shape_ok_nxt;
      pending_r      <= pending_nxt;
      tr_crc_r       <= tr_crc_nxt;
      tr_len_r       <= tr_len_nxt;
      damaged_r      <= damaged_nxt;
    end
  end

  `CLSV_ASSERT_NEXT(a_scan_cleared, fire && q_item.stream_last, pos_r == '0 && !damaged_r && !pending_r, "scan state not cleared after end of stream")
  `CLSV_ASSERT_NEXT(a_trailer_rewinds, fire && emit && ev == EV_TRAILER && !q_item.stream_last, pending_r && crc_r == crc_start_r, "trailer did not rewind the commit CRC")
  `CLSV_ASSERT_NEXT(a_commit_restarts, fire && emit && ev == EV_COMMIT && !q_item.stream_last, good_end_r == commit_start_r && crc_r == '0 && !pending_r, "accepted commit did not restart the scan")

endmodule

### rtl/core/commit_log_scan_verifier_core.sv
// ----------------------------------------------------------------------------
// Commit log scan verifier core
// Scans an append-only log byte by byte, checks trailer-closed commits by
// length and reflected CRC-32, and reports damage and the last good end.
//
//   Channel   Handshake        Payload
//   input     push / full      in_data_byte, in_record_last, in_record_is_end,
//                              in_record_bad, in_stream_last
//   result    pop / empty      out_record_event, out_last_good_end,
//                              out_scan_done, out_tail_clean
//   config    cfg_we           cfg_wdata (binary type code)
//
// One byte is taken every cycle while full is low; the back end's CRC step
// sets that pace. A result passes the middle queue and the output queue,
// both registered, before it is on the output.
// Reset is synchronous and needs no clearing pass.
// A full output queue stops the back end, and a full middle queue then
// raises full.
// ----------------------------------------------------------------------------
module commit_log_scan_verifier_core #(
  parameter int OFFSET_WIDTH = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_wdata,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_record_last,
  input  logic                    in_record_is_end,
  input  logic                    in_record_bad,
  input  logic                    in_stream_last,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              out_record_event,
  output logic [OFFSET_WIDTH-1:0] out_last_good_end,
  output logic                    out_scan_done,
  output logic                    out_tail_clean
);

  import clsv_pkg::*;

  localparam int ITEM_W = $bits(front_item_t);
  localparam int RES_W  = OFFSET_WIDTH + 4;

  logic              mid_push;
  front_item_t       mid_wdata;
  logic              mid_full;
  logic              mid_pop;
  front_item_t       mid_rdata;
  logic              mid_empty;
  logic              res_push;
  logic [RES_W-1:0]  res_wdata;
  logic              res_full;
  logic [RES_W-1:0]  res_rdata;

  clsv_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_record_last   (in_record_last),
    .in_record_is_end (in_record_is_end),
    .in_record_bad    (in_record_bad),
    .in_stream_last   (in_stream_last),
    .q_push           (mid_push),
    .q_item           (mid_wdata),
    .q_full           (mid_full)
  );

  clsv_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  clsv_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (!mid_empty),
    .q_item   (mid_rdata),
    .q_pop    (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wdata)
  );

  clsv_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign out_record_event  = res_rdata[RES_W-1 -: 2];
  assign out_last_good_end = res_rdata[OFFSET_WIDTH+1:2];
  assign out_scan_done     = res_rdata[1];
  assign out_tail_clean    = res_rdata[0];

endmodule
